@@ rtl/core/converter_operation_supervisor_macros.svh @@
// Assertion macros used by the supervisor checker.
`ifndef CONVERTER_OPERATION_SUPERVISOR_MACROS_SVH
`define CONVERTER_OPERATION_SUPERVISOR_MACROS_SVH

// Check a same-cycle implication, skipped while reset is high.
`define COS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("supervisor check failed");

// Check a next-cycle implication, skipped while reset is high.
`define COS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("supervisor check failed");

// Check a next-cycle implication that also holds across reset.
`define COS_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("supervisor check failed");

`endif

@@ rtl/core/cos_pkg.sv @@
// Types, codes and helper functions of the converter operation supervisor.
package cos_pkg;

  // Operating mode
  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_CHANGING = 3'd1,
    MODE_START_PL = 3'd2,
    MODE_PL       = 3'd3,
    MODE_END_PL   = 3'd4,
    MODE_RUN      = 3'd5
  } mode_t;

  // Item kind
  typedef enum logic [1:0] {
    KIND_COMMAND     = 2'd0,
    KIND_TICK        = 2'd1,
    KIND_CHANGE_DONE = 2'd2,
    KIND_SYNC_QUERY  = 2'd3
  } kind_t;

  // Converter codes
  localparam logic [1:0] CONV_BUCK  = 2'd0;
  localparam logic [1:0] CONV_BOOST = 2'd1;

  // Command codes
  localparam logic [5:0] CMD_ENABLE         = 6'd0;
  localparam logic [5:0] CMD_DISABLE        = 6'd1;
  localparam logic [5:0] CMD_RAMP_UP        = 6'd4;
  localparam logic [5:0] CMD_RAMP_DOWN      = 6'd5;
  localparam logic [5:0] CMD_STEP_UP        = 6'd6;
  localparam logic [5:0] CMD_STEP_DOWN      = 6'd7;
  localparam logic [5:0] CMD_RESET_REF      = 6'd8;
  localparam logic [5:0] CMD_EMERGENCY      = 6'd9;
  localparam logic [5:0] CMD_RESET_PROT     = 6'd10;
  localparam logic [5:0] CMD_CONV_FIRST     = 6'd11;
  localparam logic [5:0] CMD_CONV_LAST      = 6'd14;
  localparam logic [5:0] CMD_STRATEGY_FIRST = 6'd15;
  localparam logic [5:0] CMD_STRATEGY_LAST  = 6'd23;
  localparam logic [5:0] CMD_CORR_NONE      = 6'd24;
  localparam logic [5:0] CMD_CORR_REF_UPD   = 6'd25;
  localparam logic [5:0] CMD_CORR_PARTIAL   = 6'd26;
  localparam logic [5:0] CMD_CORR_CURRENT   = 6'd27;
  localparam logic [5:0] CMD_FLAG_FIRST     = 6'd28;
  localparam logic [5:0] CMD_FLAG_LAST      = 6'd33;
  localparam logic [5:0] CMD_HOLD_REF       = 6'd34;
  localparam logic [5:0] CMD_RELEASE_REF    = 6'd35;

  // Action strobes
  localparam logic [7:0] ACT_PWM_ON    = 8'h01;
  localparam logic [7:0] ACT_PWM_OFF   = 8'h02;
  localparam logic [7:0] ACT_CFG_PWM   = 8'h04;
  localparam logic [7:0] ACT_CFG_GPIO  = 8'h08;
  localparam logic [7:0] ACT_RST_CTRL  = 8'h10;
  localparam logic [7:0] ACT_LOAD_FILT = 8'h20;
  localparam logic [7:0] ACT_RST_FILT  = 8'h40;
  localparam logic [7:0] ACT_RST_CC    = 8'h80;

  // Option flags
  localparam logic [3:0] FLG_MODE_HOP = 4'h2;
  localparam logic [3:0] FLG_RECENT   = 4'h8;

  // Voltage steps and limits
  localparam logic [15:0]        RAMP_MV       = 16'd2;
  localparam logic [15:0]        STEP_MV       = 16'd5000;
  localparam int                 MAX_STEPS     = 65535 / 5000;
  localparam logic signed [15:0] SYNC_LIMIT_MA = 16'sd1000;
  localparam logic [3:0]         NUM_STRATEGY  = 4'd9;

  // Configuration register indexes and reset values
  localparam logic [1:0]  CFG_VOUT_MAX      = 2'd0;
  localparam logic [1:0]  CFG_CLASSIC_MASK  = 2'd1;
  localparam logic [1:0]  CFG_SWITCHED_MASK = 2'd2;
  localparam logic [15:0] VOUT_MAX_RST      = 16'd60000;
  localparam logic [8:0]  CLASSIC_RST       = 9'd273;
  localparam logic [8:0]  SWITCHED_RST      = 9'd238;

  typedef struct packed {
    kind_t              kind;
    logic [5:0]         command;
    logic               converter_change;
    logic [15:0]        input_voltage;
    logic [15:0]        output_voltage;
    logic signed [15:0] inductor_current;
  } item_t;

  typedef struct packed {
    logic [2:0]  state_code;
    logic        converter_on;
    logic [1:0]  converter_id;
    logic [3:0]  strategy_id;
    logic [15:0] reference_mv;
    logic [15:0] held_reference_mv;
    logic        holder_on;
    logic        fault_active;
    logic [3:0]  flag_bits;
    logic [1:0]  correction_mode;
    logic [7:0]  action_strobes;
    logic        sync_mode;
  } result_t;

  typedef struct packed {
    logic [15:0] vout_max;
    logic [8:0]  classic_mask;
    logic [8:0]  switched_mask;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] ref_mv;
    logic [15:0] hold_mv;
    logic        hold_on;
    logic        enable;
    logic [1:0]  conv;
    logic [3:0]  strategy;
    logic        fault;
    logic [1:0]  corr;
    logic [3:0]  flags;
  } state_t;

  // Test whether a strategy code is marked in a mask
  function automatic logic is_member(logic [8:0] mask, logic [3:0] s);
    return (s < NUM_STRATEGY) && mask[s];
  endfunction

  // Round a reference down to a whole number of voltage steps
  function automatic logic [15:0] trunc_step(logic [15:0] v);
    logic [15:0] r;
    r = '0;
    for (int k = 1; k <= MAX_STEPS; k++) begin
      if (v >= 16'(k * STEP_MV)) r = 16'(k * STEP_MV);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/cos_cfg_regs.sv @@
// Configuration registers of the supervisor.
module cos_cfg_regs
  import cos_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  // Accept writes at any time
  assign cfg_ready = 1'b1;

  // Write the addressed register, drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vout_max      <= VOUT_MAX_RST;
      cfg.classic_mask  <= CLASSIC_RST;
      cfg.switched_mask <= SWITCHED_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_VOUT_MAX:      cfg.vout_max      <= cfg_data;
        CFG_CLASSIC_MASK:  cfg.classic_mask  <= cfg_data[8:0];
        CFG_SWITCHED_MASK: cfg.switched_mask <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/cos_in_stage.sv @@
// Input register stage of the supervisor.
module cos_in_stage
  import cos_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  input  logic  advance,
  output logic  held_valid,
  output item_t held_item
);

  // Take a new transaction when empty or when the held one moves on
  assign item_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held_item <= item;
    end
  end

endmodule

@@ rtl/core/cos_engine.sv @@
// Supervisor state registers and per-item update logic.
module cos_engine
  import cos_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    commit,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  state_t      st;
  state_t      st_next;
  logic [7:0]  strobes;
  logic        sync;
  logic [5:0]  cmd;
  logic [15:0] target;
  logic [15:0] delta;
  logic [16:0] sum;
  logic [15:0] up_val;
  logic [15:0] down_val;
  logic [15:0] adj_val;
  logic        is_up;
  logic [19:0] vout_x10;
  logic [19:0] vin_x9;
  logic        preload_done;
  logic [2:0]  flag_sel;
  logic [3:0]  flag_bit;

  assign cmd = item.command;

  // Ramp and step adjust of the active reference, clamped at 0 and vout_max
  always_comb begin
    target   = st.hold_on ? st.hold_mv : st.ref_mv;
    delta    = (cmd == CMD_RAMP_UP || cmd == CMD_RAMP_DOWN) ? RAMP_MV : STEP_MV;
    is_up    = (cmd == CMD_RAMP_UP || cmd == CMD_STEP_UP);
    sum      = {1'b0, target} + {1'b0, delta};
    up_val   = (sum > {1'b0, cfg.vout_max}) ? cfg.vout_max : sum[15:0];
    down_val = (target < delta) ? 16'd0 : target - delta;
    adj_val  = is_up ? up_val : down_val;
  end

  // Pre-load end test: vout >= 0.9 * vin as 10 * vout >= 9 * vin
  assign vout_x10     = {1'b0, item.output_voltage, 3'b000} + {3'b000, item.output_voltage, 1'b0};
  assign vin_x9       = {1'b0, item.input_voltage, 3'b000} + {4'b0000, item.input_voltage};
  assign preload_done = (vout_x10 >= vin_x9);

  // Option flag select: pairs of set and clear codes
  assign flag_sel = 3'(cmd - CMD_FLAG_FIRST);
  assign flag_bit = 4'b0001 << flag_sel[2:1];

  // Compute the state after this item
  always_comb begin
    st_next = st;
    strobes = '0;
    sync    = 1'b0;
    unique case (item.kind)
      KIND_COMMAND: begin
        priority if (cmd == CMD_ENABLE) begin
          if (st.mode == MODE_OFF) begin
            strobes = ACT_RST_CTRL | ACT_LOAD_FILT | ACT_RST_CC;
            if (st.conv == CONV_BOOST) begin
              st_next.enable = 1'b0;
              st_next.mode   = MODE_START_PL;
              st_next.ref_mv = '0;
              st_next.conv   = CONV_BUCK;
            end else begin
              st_next.mode   = MODE_RUN;
              st_next.enable = 1'b1;
              if (is_member(cfg.classic_mask, st.strategy)) strobes = strobes | ACT_PWM_ON;
            end
            st_next.flags = st.flags | FLG_RECENT;
          end
        end else if (cmd == CMD_DISABLE) begin
          if (st.mode != MODE_OFF) begin
            st_next.enable = 1'b0;
            strobes        = ACT_PWM_OFF;
            if (st.mode == MODE_START_PL || st.mode == MODE_PL || st.mode == MODE_END_PL) begin
              st_next.conv = CONV_BOOST;
              st_next.mode = MODE_CHANGING;
            end else begin
              st_next.mode = MODE_OFF;
            end
          end
        end else if (cmd >= CMD_RAMP_UP && cmd <= CMD_STEP_DOWN) begin
          if (st.hold_on) st_next.hold_mv = adj_val;
          else st_next.ref_mv = adj_val;
          if (cmd == CMD_STEP_UP || cmd == CMD_STEP_DOWN) st_next.flags = st.flags | FLG_RECENT;
        end else if (cmd == CMD_RESET_REF) begin
          if (st.hold_on) st_next.hold_mv = '0;
          else st_next.ref_mv = '0;
        end else if (cmd == CMD_EMERGENCY) begin
          st_next.fault = 1'b1;
        end else if (cmd == CMD_RESET_PROT) begin
          st_next.fault = 1'b0;
        end else if (cmd >= CMD_CONV_FIRST && cmd <= CMD_CONV_LAST) begin
          if (st.mode == MODE_OFF) begin
            st_next.enable = 1'b0;
            st_next.conv   = 2'(cmd - CMD_CONV_FIRST);
            st_next.mode   = MODE_CHANGING;
          end
        end else if (cmd >= CMD_STRATEGY_FIRST && cmd <= CMD_STRATEGY_LAST) begin
          if (st.mode == MODE_OFF) begin
            st_next.enable   = 1'b0;
            st_next.strategy = 4'(cmd - CMD_STRATEGY_FIRST);
            st_next.mode     = MODE_CHANGING;
            if (is_member(cfg.classic_mask, st_next.strategy)) strobes = ACT_CFG_PWM;
            else if (is_member(cfg.switched_mask, st_next.strategy)) strobes = ACT_CFG_GPIO;
          end
        end else if (cmd >= CMD_CORR_NONE && cmd <= CMD_CORR_CURRENT) begin
          st_next.corr = cmd[1:0];
          if (cmd == CMD_CORR_REF_UPD) strobes = ACT_RST_CTRL;
          else if (cmd == CMD_CORR_PARTIAL) strobes = ACT_RST_FILT;
          else if (cmd == CMD_CORR_CURRENT) strobes = ACT_RST_CC;
        end else if (cmd >= CMD_FLAG_FIRST && cmd <= CMD_FLAG_LAST) begin
          if (!flag_sel[0]) st_next.flags = st.flags | flag_bit;
          else st_next.flags = st.flags & ~flag_bit;
        end else if (cmd == CMD_HOLD_REF) begin
          st_next.hold_mv = st.ref_mv;
          st_next.hold_on = 1'b1;
        end else if (cmd == CMD_RELEASE_REF) begin
          st_next.ref_mv  = st.hold_mv;
          st_next.hold_on = 1'b0;
        end else begin
          // Drop DAC and unknown codes
        end
      end
      KIND_TICK: begin
        priority if (st.mode == MODE_START_PL) begin
          if (item.converter_change) begin
            st_next.mode   = MODE_PL;
            st_next.enable = 1'b1;
          end
          if (is_member(cfg.classic_mask, st.strategy)) strobes = ACT_PWM_ON;
        end else if (st.mode == MODE_PL) begin
          if (preload_done) begin
            st_next.enable = 1'b0;
            st_next.conv   = CONV_BOOST;
            st_next.mode   = MODE_END_PL;
          end
        end else if (st.mode == MODE_END_PL) begin
          if (item.converter_change) begin
            st_next.ref_mv = trunc_step(st.ref_mv);
            st_next.mode   = MODE_RUN;
            st_next.enable = 1'b1;
          end
          strobes = ACT_RST_CTRL | ACT_LOAD_FILT | ACT_RST_CC;
        end else begin
          // Drop ticks outside pre-load
        end
      end
      KIND_CHANGE_DONE: begin
        if (st.mode == MODE_CHANGING) st_next.mode = MODE_OFF;
      end
      KIND_SYNC_QUERY: begin
        sync = (st.flags & FLG_MODE_HOP) != 4'h0 ? (item.inductor_current > SYNC_LIMIT_MA)
                                                 : 1'b1;
      end
      default: ;
    endcase
  end

  // Advance the state once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode     <= MODE_OFF;
      st.ref_mv   <= '0;
      st.hold_mv  <= '0;
      st.hold_on  <= 1'b0;
      st.enable   <= 1'b0;
      st.conv     <= CONV_BUCK;
      st.strategy <= '0;
      st.fault    <= 1'b0;
      st.corr     <= '0;
      st.flags    <= '0;
    end else if (commit) begin
      st <= st_next;
    end
  end

  // Form the result from the updated state
  always_comb begin
    res.state_code        = st_next.mode;
    res.converter_on      = st_next.enable;
    res.converter_id      = st_next.conv;
    res.strategy_id       = st_next.strategy;
    res.reference_mv      = st_next.ref_mv;
    res.held_reference_mv = st_next.hold_mv;
    res.holder_on         = st_next.hold_on;
    res.fault_active      = st_next.fault;
    res.flag_bits         = st_next.flags;
    res.correction_mode   = st_next.corr;
    res.action_strobes    = strobes;
    res.sync_mode         = sync;
  end

endmodule

@@ rtl/core/cos_out_stage.sv @@
// Result register stage of the supervisor.
module cos_out_stage
  import cos_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    can_load,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  // Free when empty or when the waiting transaction is taken
  assign can_load = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      result <= res;
    end
  end

endmodule

@@ rtl/core/converter_operation_supervisor.sv @@
// Top level of the DC-DC converter operation supervisor.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------
//   item     | item_valid / item_ready   | item   (cos_pkg::item_t)
//   result   | result_valid/result_ready | result (cos_pkg::result_t)
//   cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One item per cycle unless the result side stalls; an item passes the input then the result register.
// The state update is one pass of logic between the input and result registers.
// A stall on the result side holds the result register and then the input register.
// cfg_ready is always high; writes take effect on the next cycle.
// Synchronous reset clears the mode state and both valid flags, and loads the cfg reset values.
module converter_operation_supervisor
  import cos_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  logic    held_valid;
  item_t   held_item;
  logic    can_load;
  logic    advance;
  result_t res;

  // Move the held item into the result register when there is room
  assign advance = held_valid && can_load;

  cos_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cos_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  cos_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .item   (held_item),
    .cfg    (cfg),
    .res    (res)
  );

  cos_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance),
    .res          (res),
    .can_load     (can_load),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

@@ rtl/core/cos_checker.sv @@
// Port-level checks of the supervisor, bound to the top level.
`include "converter_operation_supervisor_macros.svh"

module cos_checker
  import cos_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // A stalled result keeps its payload
  `COS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

  // The converter runs only in running or pre-load mode
  `COS_ASSERT_IMPL(a_enable_mode, result_valid && result.converter_on, result.state_code == MODE_RUN || result.state_code == MODE_PL)

  // Reset empties the result register
  `COS_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !result_valid)

  // An accepted transaction reaches the result register when it has room
  `COS_ASSERT_NEXT(a_flow, (item_valid && item_ready) ##1 (!result_valid || result_ready), result_valid)

endmodule

bind converter_operation_supervisor cos_checker u_cos_checker (.*);
